// ----- rtl/sre_pkg.sv -----
// shared types, constants and fixed-point helpers for the spectral radius estimator
// no dependencies
package sre_pkg;

   localparam int IDX_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ITER_W     = 24;
   localparam int PROD_W     = 40;
   localparam int DVD_W      = 62;
   localparam int DVS_W      = 32;
   localparam int RAD_W      = 64;
   localparam int ROOT_W     = 32;
   localparam int CNT_W      = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 3'd4;

   localparam logic [1:0] MODE_ANALYZE = 2'd0;
   localparam logic [1:0] MODE_GERSH   = 2'd1;
   localparam logic [1:0] MODE_POWER   = 2'd2;

   localparam logic [1:0] PH_ADDR = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_ACC  = 2'd2;

   localparam logic VSEL_ITER = 1'b0;
   localparam logic VSEL_PROD = 1'b1;

   localparam logic signed [65:0] RAYL_LIM = 66'sh4000000000000000;

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_GERSH     = 13'b0000000000010,
      S_DECIDE    = 13'b0000000000100,
      S_INIT_DIV  = 13'b0000000001000,
      S_INIT_SQRT = 13'b0000000010000,
      S_INIT_FILL = 13'b0000000100000,
      S_JV        = 13'b0000001000000,
      S_RAYL      = 13'b0000010000000,
      S_CHECK     = 13'b0000100000000,
      S_NORM      = 13'b0001000000000,
      S_ROOT      = 13'b0010000000000,
      S_SCALE     = 13'b0100000000000,
      S_DONE      = 13'b1000000000000
   } state_type;

   // floor shift by 22, then clamp to signed 40 bits
   function automatic logic signed [PROD_W-1:0] clamp40(input logic signed [63:0] x);
      logic signed [63:0] s;
      s = x >>> 22;
      if (s > 64'sh0000007FFFFFFFFF) begin
         clamp40 = 40'sh7FFFFFFFFF;
      end else if (s < -64'sh0000008000000000) begin
         clamp40 = 40'sh8000000000;
      end else begin
         clamp40 = s[PROD_W-1:0];
      end
   endfunction

   function automatic logic [31:0] abs_sat32(input logic signed [PROD_W-1:0] x);
      logic [PROD_W-1:0] a;
      a = x[PROD_W-1] ? PROD_W'(-x) : x;
      abs_sat32 = (a[PROD_W-1:32] != '0) ? 32'hFFFFFFFF : a[31:0];
   endfunction

endpackage

// ----- rtl/sre_ifs.sv -----
// channel interfaces: element request, result response, register write
// depends on sre_pkg
interface sre_req_if #(parameter int ELEMENT_BITS = 24);
   logic                                valid;
   logic                                ready;
   logic [sre_pkg::IDX_W-1:0]           row_index;
   logic [sre_pkg::IDX_W-1:0]           col_index;
   logic signed [ELEMENT_BITS-1:0]      element;
   logic                                last_element;
   modport source(output valid, row_index, col_index, element, last_element, input ready);
   modport sink(input valid, row_index, col_index, element, last_element, output ready);
endinterface

interface sre_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] spectral_bound;
   logic        contractive;
   logic [31:0] gershgorin_value;
   logic        used_power_iteration;
   modport source(output valid, spectral_bound, contractive, gershgorin_value,
                  used_power_iteration, input ready);
   modport sink(input valid, spectral_bound, contractive, gershgorin_value,
                used_power_iteration, output ready);
endinterface

interface sre_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sre_pkg::CSR_IDX_W-1:0]      index;
   logic [sre_pkg::CSR_DATA_W-1:0]     wdata;
   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

// ----- rtl/spectral_radius_estimator.sv -----
// spectral radius estimator top level: matrix store, vector store and solve sequencer
// depends on sre_pkg, sre_ifs, sre_div, sre_sqrt
// Matrix elements load at one transaction per cycle into a synchronous matrix memory. A
// transaction marked last_element starts a solve during which no element is taken. The
// Gershgorin pass reads each of the n*n active entries in turn. Power iteration, when
// selected, first forms the start vector with the bit-serial divider and the square root,
// then per round runs the matrix-vector product, the Rayleigh quotient, the norm and the
// normalizing, where the divider sets the pace; at most max_iterations rounds run. The result
// sits in an output register, so the next elements load while it waits to be taken.
module spectral_radius_estimator #(
   parameter int N_MAX        = 16,
   parameter int ELEMENT_BITS = 24
) (
   input  logic          clock,
   input  logic          reset,
   sre_req_if.sink       req_if,
   sre_rsp_if.source     rsp_if,
   sre_csr_if.sink       csr_if
);
   localparam int IW     = (N_MAX > 1) ? $clog2(N_MAX) : 1;
   localparam int CW     = $clog2(N_MAX + 1);
   localparam int MDEPTH = N_MAX * N_MAX;
   localparam int MAW    = (N_MAX > 1) ? $clog2(MDEPTH) : 1;
   localparam int VAW    = IW + 1;
   localparam int GW     = ELEMENT_BITS + CW;
   localparam int MW     = ELEMENT_BITS + sre_pkg::ITER_W;
   localparam int JW     = MW + CW;

   // memories
   logic signed [ELEMENT_BITS-1:0]     mat_mem [MDEPTH];
   logic signed [sre_pkg::PROD_W-1:0]  vec_mem [2**VAW];
   logic signed [ELEMENT_BITS-1:0]     mat_rd_ff;
   logic signed [sre_pkg::PROD_W-1:0]  vec_a_ff, vec_b_ff;

   sre_pkg::state_type                 state_ff, state_in;
   logic [1:0]                         ph_ff, ph_in;
   logic [CW-1:0]                      i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic [CW-1:0]                      i_nx, j_nx, n_sel;
   logic [GW-1:0]                      gacc_ff, gacc_in, gbest_ff, gbest_in;
   logic signed [JW-1:0]               jacc_ff, jacc_in;
   logic signed [65:0]                 racc_ff, racc_in;
   logic [63:0]                        sq_ff, sq_in;
   logic signed [sre_pkg::PROD_W-1:0]  prev_ff, prev_in;
   logic [sre_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [sre_pkg::ITER_W-1:0]         v0_ff, v0_in;
   logic [31:0]                        nrm_ff, nrm_in;
   logic [31:0]                        est_ff, est_in;
   logic [31:0]                        g32_ff, g32_in;
   logic                               usep_ff, usep_in;
   logic signed [64:0]                 mul_ff;

   logic [4:0]                         size_ff;
   logic [15:0]                        eps_ff, tol_ff;
   logic [sre_pkg::CNT_W-1:0]          maxit_ff;
   logic [1:0]                         mode_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [31:0]                        rsp_bound_ff, rsp_bound_in;
   logic                               rsp_contr_ff, rsp_contr_in;
   logic [31:0]                        rsp_gv_ff, rsp_gv_in;
   logic                               rsp_usep_ff, rsp_usep_in;

   logic                               req_acc, mat_we;
   logic [MAW-1:0]                     mat_waddr, mat_raddr;
   logic [VAW-1:0]                     vec_raddr_a, vec_raddr_b, vec_waddr;
   logic                               vec_we;
   logic signed [sre_pkg::PROD_W-1:0]  vec_wdata;

   logic                               div_start, div_done;
   logic [sre_pkg::DVD_W-1:0]          div_dvd, div_q;
   logic [sre_pkg::DVS_W-1:0]          div_dvs;
   logic                               sqrt_start, sqrt_done;
   logic [sre_pkg::RAD_W-1:0]          sqrt_rad;
   logic [sre_pkg::ROOT_W-1:0]         sqrt_root;

   logic signed [40:0]                 mul_a;
   logic signed [32:0]                 mul_b;
   logic signed [73:0]                 mul_full;
   logic [ELEMENT_BITS-1:0]            mat_abs;
   logic [GW-1:0]                      row_sum;
   logic [63:0]                        best64;
   logic [31:0]                        g32;
   logic [16:0]                        thr;
   logic                               use_pow;
   logic signed [JW-1:0]               jsum;
   logic signed [65:0]                 rsum, rclamp;
   logic signed [sre_pkg::PROD_W-1:0]  lam;
   logic signed [sre_pkg::PROD_W:0]    diff;
   logic [sre_pkg::PROD_W:0]           diff_abs;
   logic [sre_pkg::PROD_W-1:0]         pabs;
   logic [63:0]                        sq_t;
   logic [64:0]                        sq_wide;
   logic [63:0]                        sq_sum;
   logic signed [sre_pkg::ITER_W-1:0]  vnew;

   sre_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(div_dvs), .done(div_done), .quotient(div_q)
   );

   sre_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .radicand(sqrt_rad),
      .done(sqrt_done), .root(sqrt_root)
   );

   // configuration registers
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= 5'd16;
         eps_ff   <= 16'd655;
         maxit_ff <= 10'd100;
         tol_ff   <= 16'd1;
         mode_ff  <= sre_pkg::MODE_ANALYZE;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            sre_pkg::CSR_MATRIX_SIZE:    size_ff  <= csr_if.wdata[4:0];
            sre_pkg::CSR_EPSILON:        eps_ff   <= csr_if.wdata;
            sre_pkg::CSR_MAX_ITERATIONS: maxit_ff <= csr_if.wdata[sre_pkg::CNT_W-1:0];
            sre_pkg::CSR_TOLERANCE:      tol_ff   <= csr_if.wdata;
            sre_pkg::CSR_MODE:           mode_ff  <= csr_if.wdata[1:0];
            default: ;
         endcase
      end
   end

   // element load
   assign req_if.ready = (state_ff == sre_pkg::S_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign mat_we       = req_acc && (32'(req_if.row_index) < N_MAX)
                         && (32'(req_if.col_index) < N_MAX);
   assign mat_waddr    = MAW'(32'(req_if.row_index) * N_MAX + 32'(req_if.col_index));
   assign mat_raddr    = MAW'(32'(i_ff) * N_MAX + 32'(j_ff));
   assign vec_raddr_a  = {sre_pkg::VSEL_ITER,
                          (state_ff == sre_pkg::S_JV) ? j_ff[IW-1:0] : i_ff[IW-1:0]};
   assign vec_raddr_b  = {sre_pkg::VSEL_PROD, i_ff[IW-1:0]};

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_waddr] <= req_if.element;
      end
      mat_rd_ff <= mat_mem[mat_raddr];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[vec_waddr] <= vec_wdata;
      end
      vec_a_ff <= vec_mem[vec_raddr_a];
      vec_b_ff <= vec_mem[vec_raddr_b];
   end

   // shared multiplier
   always_comb begin
      if (state_ff == sre_pkg::S_JV) begin
         mul_a = 41'(mat_rd_ff);
         mul_b = 33'($signed(vec_a_ff[sre_pkg::ITER_W-1:0]));
      end else if (state_ff == sre_pkg::S_RAYL) begin
         mul_a = 41'(vec_b_ff);
         mul_b = 33'($signed(vec_a_ff[sre_pkg::ITER_W-1:0]));
      end else begin
         mul_a = {9'b0, pabs[31:0]};
         mul_b = {1'b0, pabs[31:0]};
      end
   end

   assign mul_full = mul_a * mul_b;

   always_ff @(posedge clock) begin
      mul_ff <= mul_full[64:0];
   end

   // datapath terms
   assign i_nx     = i_ff + CW'(1);
   assign j_nx     = j_ff + CW'(1);
   assign n_sel    = (32'(size_ff) > N_MAX) ? CW'(N_MAX) : CW'(size_ff);
   assign mat_abs  = mat_rd_ff[ELEMENT_BITS-1] ? ELEMENT_BITS'(-mat_rd_ff) : mat_rd_ff;
   assign row_sum  = gacc_ff + GW'(mat_abs);
   assign best64   = 64'(gbest_ff);
   assign g32      = (best64 > 64'h00000000FFFFFFFF) ? 32'hFFFFFFFF : best64[31:0];
   assign thr      = 17'h10000 - 17'(eps_ff);
   assign jsum     = jacc_ff + JW'(mul_ff);
   assign rsum     = racc_ff + 66'(mul_ff);
   assign rclamp   = (rsum > sre_pkg::RAYL_LIM) ? sre_pkg::RAYL_LIM :
                     ((rsum < -sre_pkg::RAYL_LIM) ? -sre_pkg::RAYL_LIM : rsum);
   assign lam      = sre_pkg::clamp40($signed(racc_ff[63:0]));
   assign diff     = 41'(lam) - 41'(prev_ff);
   assign diff_abs = diff[sre_pkg::PROD_W] ? 41'(-diff) : diff;
   assign pabs     = vec_b_ff[sre_pkg::PROD_W-1] ? sre_pkg::PROD_W'(-vec_b_ff) : vec_b_ff;
   assign sq_t     = (pabs[sre_pkg::PROD_W-1:32] != '0) ? 64'hFFFFFFFFFFFFFFFF : mul_ff[63:0];
   assign sq_wide  = {1'b0, sq_ff} + {1'b0, sq_t};
   assign sq_sum   = sq_wide[64] ? 64'hFFFFFFFFFFFFFFFF : sq_wide[63:0];

   always_comb begin
      case (mode_ff)
         sre_pkg::MODE_GERSH: use_pow = 1'b0;
         sre_pkg::MODE_POWER: use_pow = 1'b1;
         default: use_pow = (33'(g32) < 33'(thr)) && ((37'(g32) * 37'd20) > (37'(thr) * 37'd19));
      endcase
   end

   always_comb begin
      if (!vec_b_ff[sre_pkg::PROD_W-1]) begin
         vnew = (div_q > 62'h7FFFFF) ? 24'sh7FFFFF : $signed(div_q[sre_pkg::ITER_W-1:0]);
      end else begin
         vnew = (div_q >= 62'h800000) ? 24'sh800000 :
                $signed(sre_pkg::ITER_W'(-div_q[sre_pkg::ITER_W-1:0]));
      end
   end

   // solve sequencer
   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      gacc_in      = gacc_ff;
      gbest_in     = gbest_ff;
      jacc_in      = jacc_ff;
      racc_in      = racc_ff;
      sq_in        = sq_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      v0_in        = v0_ff;
      nrm_in       = nrm_ff;
      est_in       = est_ff;
      g32_in       = g32_ff;
      usep_in      = usep_ff;
      div_start    = 1'b0;
      div_dvd      = '0;
      div_dvs      = '0;
      sqrt_start   = 1'b0;
      sqrt_rad     = '0;
      vec_we       = 1'b0;
      vec_waddr    = {sre_pkg::VSEL_ITER, i_ff[IW-1:0]};
      vec_wdata    = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_bound_in = rsp_bound_ff;
      rsp_contr_in = rsp_contr_ff;
      rsp_gv_in    = rsp_gv_ff;
      rsp_usep_in  = rsp_usep_ff;
      case (state_ff)
         sre_pkg::S_IDLE: begin
            if (req_acc && req_if.last_element) begin
               n_in     = n_sel;
               i_in     = '0;
               j_in     = '0;
               cnt_in   = '0;
               ph_in    = sre_pkg::PH_ADDR;
               gacc_in  = '0;
               gbest_in = '0;
               state_in = (n_sel == '0) ? sre_pkg::S_DECIDE : sre_pkg::S_GERSH;
            end
         end
         sre_pkg::S_GERSH: begin
            if (ph_ff == sre_pkg::PH_ADDR) begin
               ph_in = sre_pkg::PH_MUL;
            end else begin
               ph_in = sre_pkg::PH_ADDR;
               if (j_nx == n_ff) begin
                  if (row_sum > gbest_ff) begin
                     gbest_in = row_sum;
                  end
                  gacc_in = '0;
                  j_in    = '0;
                  i_in    = i_nx;
                  if (i_nx == n_ff) begin
                     state_in = sre_pkg::S_DECIDE;
                  end
               end else begin
                  gacc_in = row_sum;
                  j_in    = j_nx;
               end
            end
         end
         sre_pkg::S_DECIDE: begin
            usep_in = use_pow;
            g32_in  = g32;
            cnt_in  = '0;
            prev_in = '0;
            if (!use_pow) begin
               est_in   = g32;
               state_in = sre_pkg::S_DONE;
            end else if (n_ff == '0 || maxit_ff == '0) begin
               est_in   = '0;
               state_in = sre_pkg::S_DONE;
            end else begin
               div_start = 1'b1;
               div_dvd   = sre_pkg::DVD_W'(1) << 44;
               div_dvs   = sre_pkg::DVS_W'(n_ff);
               state_in  = sre_pkg::S_INIT_DIV;
            end
         end
         sre_pkg::S_INIT_DIV: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               sqrt_rad   = sre_pkg::RAD_W'(div_q);
               state_in   = sre_pkg::S_INIT_SQRT;
            end
         end
         sre_pkg::S_INIT_SQRT: begin
            if (sqrt_done) begin
               v0_in    = sqrt_root[sre_pkg::ITER_W-1:0];
               i_in     = '0;
               state_in = sre_pkg::S_INIT_FILL;
            end
         end
         sre_pkg::S_INIT_FILL: begin
            vec_we    = 1'b1;
            vec_waddr = {sre_pkg::VSEL_ITER, i_ff[IW-1:0]};
            vec_wdata = {16'b0, v0_ff};
            i_in      = i_nx;
            if (i_nx == n_ff) begin
               i_in     = '0;
               j_in     = '0;
               jacc_in  = '0;
               ph_in    = sre_pkg::PH_ADDR;
               state_in = sre_pkg::S_JV;
            end
         end
         sre_pkg::S_JV: begin
            if (ph_ff == sre_pkg::PH_ADDR) begin
               ph_in = sre_pkg::PH_MUL;
            end else if (ph_ff == sre_pkg::PH_MUL) begin
               ph_in = sre_pkg::PH_ACC;
            end else begin
               ph_in = sre_pkg::PH_ADDR;
               if (j_nx == n_ff) begin
                  vec_we    = 1'b1;
                  vec_waddr = {sre_pkg::VSEL_PROD, i_ff[IW-1:0]};
                  vec_wdata = sre_pkg::clamp40(64'(jsum));
                  jacc_in   = '0;
                  j_in      = '0;
                  i_in      = i_nx;
                  if (i_nx == n_ff) begin
                     i_in     = '0;
                     racc_in  = '0;
                     state_in = sre_pkg::S_RAYL;
                  end
               end else begin
                  jacc_in = jsum;
                  j_in    = j_nx;
               end
            end
         end
         sre_pkg::S_RAYL: begin
            if (ph_ff == sre_pkg::PH_ADDR) begin
               ph_in = sre_pkg::PH_MUL;
            end else if (ph_ff == sre_pkg::PH_MUL) begin
               ph_in = sre_pkg::PH_ACC;
            end else begin
               ph_in   = sre_pkg::PH_ADDR;
               racc_in = rclamp;
               i_in    = i_nx;
               if (i_nx == n_ff) begin
                  state_in = sre_pkg::S_CHECK;
               end
            end
         end
         sre_pkg::S_CHECK: begin
            cnt_in = cnt_ff + sre_pkg::CNT_W'(1);
            if (diff_abs < 41'(tol_ff)) begin
               est_in   = sre_pkg::abs_sat32(lam);
               state_in = sre_pkg::S_DONE;
            end else begin
               prev_in = lam;
               if (cnt_ff + sre_pkg::CNT_W'(1) == maxit_ff) begin
                  est_in   = sre_pkg::abs_sat32(lam);
                  state_in = sre_pkg::S_DONE;
               end else begin
                  i_in     = '0;
                  sq_in    = '0;
                  ph_in    = sre_pkg::PH_ADDR;
                  state_in = sre_pkg::S_NORM;
               end
            end
         end
         sre_pkg::S_NORM: begin
            if (ph_ff == sre_pkg::PH_ADDR) begin
               ph_in = sre_pkg::PH_MUL;
            end else if (ph_ff == sre_pkg::PH_MUL) begin
               ph_in = sre_pkg::PH_ACC;
            end else begin
               ph_in = sre_pkg::PH_ADDR;
               sq_in = sq_sum;
               i_in  = i_nx;
               if (i_nx == n_ff) begin
                  sqrt_start = 1'b1;
                  sqrt_rad   = sq_sum;
                  state_in   = sre_pkg::S_ROOT;
               end
            end
         end
         sre_pkg::S_ROOT: begin
            if (sqrt_done) begin
               if (sqrt_root == '0) begin
                  est_in   = sre_pkg::abs_sat32(prev_ff);
                  state_in = sre_pkg::S_DONE;
               end else begin
                  nrm_in   = sqrt_root;
                  i_in     = '0;
                  ph_in    = sre_pkg::PH_ADDR;
                  state_in = sre_pkg::S_SCALE;
               end
            end
         end
         sre_pkg::S_SCALE: begin
            if (ph_ff == sre_pkg::PH_ADDR) begin
               ph_in = sre_pkg::PH_MUL;
            end else if (ph_ff == sre_pkg::PH_MUL) begin
               div_start = 1'b1;
               div_dvd   = {pabs, 22'b0};
               div_dvs   = nrm_ff;
               ph_in     = sre_pkg::PH_ACC;
            end else if (div_done) begin
               vec_we    = 1'b1;
               vec_waddr = {sre_pkg::VSEL_ITER, i_ff[IW-1:0]};
               vec_wdata = sre_pkg::PROD_W'(vnew);
               ph_in     = sre_pkg::PH_ADDR;
               i_in      = i_nx;
               if (i_nx == n_ff) begin
                  i_in     = '0;
                  j_in     = '0;
                  jacc_in  = '0;
                  state_in = sre_pkg::S_JV;
               end
            end
         end
         sre_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bound_in = est_ff;
               rsp_contr_in = 33'(est_ff) < 33'(thr);
               rsp_gv_in    = g32_ff;
               rsp_usep_in  = usep_ff;
               state_in     = sre_pkg::S_IDLE;
            end
         end
         default: state_in = sre_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sre_pkg::S_IDLE;
         ph_ff        <= sre_pkg::PH_ADDR;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         prev_ff      <= '0;
         gbest_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         prev_ff      <= prev_in;
         gbest_ff     <= gbest_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      n_ff         <= n_in;
      gacc_ff      <= gacc_in;
      jacc_ff      <= jacc_in;
      racc_ff      <= racc_in;
      sq_ff        <= sq_in;
      v0_ff        <= v0_in;
      nrm_ff       <= nrm_in;
      est_ff       <= est_in;
      g32_ff       <= g32_in;
      usep_ff      <= usep_in;
      rsp_bound_ff <= rsp_bound_in;
      rsp_contr_ff <= rsp_contr_in;
      rsp_gv_ff    <= rsp_gv_in;
      rsp_usep_ff  <= rsp_usep_in;
   end

   assign rsp_if.valid                = rsp_valid_ff;
   assign rsp_if.spectral_bound       = rsp_bound_ff;
   assign rsp_if.contractive          = rsp_contr_ff;
   assign rsp_if.gershgorin_value     = rsp_gv_ff;
   assign rsp_if.used_power_iteration = rsp_usep_ff;

   // result always lands once the output register frees up
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sre_pkg::S_DONE && (!rsp_valid_ff || rsp_if.ready)) |=> rsp_valid_ff)
      else $error("finished solve did not present a result");

   // round count never passes the cap while solving
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sre_pkg::S_IDLE) |-> (cnt_ff <= maxit_ff))
      else $error("iteration count above cap");

   // quotient only arrives where the sequencer waits for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == sre_pkg::S_INIT_DIV
                    || (state_ff == sre_pkg::S_SCALE && ph_ff == sre_pkg::PH_ACC)))
      else $error("divider finished outside a wait state");
endmodule

// ----- rtl/sre_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on sre_pkg
module sre_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sre_pkg::DVD_W-1:0]     dividend,
   input  logic [sre_pkg::DVS_W-1:0]     divisor,
   output logic                          done,
   output logic [sre_pkg::DVD_W-1:0]     quotient
);
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [5:0]                    cnt_ff, cnt_in;
   logic [sre_pkg::DVD_W-1:0]     dvd_ff, dvd_in;
   logic [sre_pkg::DVS_W-1:0]     dvs_ff, dvs_in;
   logic [sre_pkg::DVS_W-1:0]     rem_ff, rem_in;
   logic [sre_pkg::DVD_W-1:0]     q_ff, q_in;
   logic [sre_pkg::DVS_W:0]       trial;
   logic                          ge;

   assign trial = {rem_ff, dvd_ff[sre_pkg::DVD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(sre_pkg::DVD_W - 1);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? sre_pkg::DVS_W'(trial - {1'b0, dvs_ff}) : trial[sre_pkg::DVS_W-1:0];
         q_in   = {q_ff[sre_pkg::DVD_W-2:0], ge};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

// ----- rtl/sre_sqrt.sv -----
// integer square root, two radicand bits per cycle
// depends on sre_pkg
module sre_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sre_pkg::RAD_W-1:0]     radicand,
   output logic                          done,
   output logic [sre_pkg::ROOT_W-1:0]    root
);
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [sre_pkg::RAD_W-1:0]     x_ff, x_in;
   logic [sre_pkg::RAD_W-1:0]     r_ff, r_in;
   logic [sre_pkg::RAD_W-1:0]     bit_ff, bit_in;
   logic [sre_pkg::RAD_W-1:0]     sum;

   assign sum = r_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         x_in    = radicand;
         r_in    = '0;
         bit_in  = sre_pkg::RAD_W'(1) << (sre_pkg::RAD_W - 2);
      end else if (busy_ff) begin
         if (x_ff >= sum) begin
            x_in = x_ff - sum;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[sre_pkg::ROOT_W-1:0];
endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for spectral_radius_estimator: loads matrices, writes registers,
// predicts each radius result in fixed point and compares it with the block's response
// depends on sre_pkg, sre_ifs and the block's rtl
module testbench;

   localparam int STORE_N     = 16;
   localparam int TARGET_ITEMS = 1600;
   localparam longint CYCLE_LIMIT = 100_000_000;

   typedef struct {
      logic [31:0] bound;
      logic        contractive;
      logic [31:0] gersh;
      logic        used_power;
   } radius_result_type;

   typedef enum int {FILL_WIDE, FILL_SMALL, FILL_BORDER, FILL_EXTREME} fill_kind_type;

   logic clock;
   logic reset;

   sre_req_if #(.ELEMENT_BITS(24)) req();
   sre_rsp_if rsp();
   sre_csr_if csr();

   spectral_radius_estimator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   // predictor state
   logic signed [23:0] matrix_copy [STORE_N*STORE_N];
   bit                 written [STORE_N*STORE_N];
   logic [4:0]         cfg_size;
   logic [15:0]        cfg_epsilon;
   logic [9:0]         cfg_max_iter;
   logic [15:0]        cfg_tolerance;
   logic [1:0]         cfg_mode;

   radius_result_type pending_radii [$];
   int             fail_count;
   int             sent_count;
   bit             no_gaps;
   longint         cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(input logic signed [65:0] x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic logic [31:0] sat32(input logic [63:0] x);
      return x > 64'hFFFFFFFF ? 32'hFFFFFFFF : x[31:0];
   endfunction

   function automatic logic signed [65:0] clamp_bits(input logic signed [65:0] x, input int bits);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = (66'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return x > hi ? hi : (x < lo ? lo : x);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] row_sum_bound(input int n);
      logic [63:0] best;
      logic [63:0] row_sum;
      best = 0;
      for (int i = 0; i < n; i++) begin
         row_sum = 0;
         for (int j = 0; j < n; j++)
            row_sum += magnitude(66'(matrix_copy[i*STORE_N+j]));
         if (row_sum > best) best = row_sum;
      end
      return sat32(best);
   endfunction

   function automatic logic [63:0] power_estimate(input int n);
      logic signed [65:0] vec [STORE_N];
      logic signed [65:0] jv [STORE_N];
      logic signed [65:0] s;
      logic signed [65:0] acc;
      logic signed [65:0] lam;
      logic signed [65:0] prev;
      logic signed [65:0] lim;
      logic [63:0] sq;
      logic [63:0] t;
      logic [63:0] a;
      logic [63:0] nrm;
      logic [63:0] q;
      logic [63:0] v0;
      prev = 0;
      lim = 66'sd1 <<< 62;
      if (n == 0) return 0;
      v0 = int_sqrt((64'd1 << 44) / n);
      for (int i = 0; i < n; i++) vec[i] = clamp_bits(66'(v0), 24);
      for (int it = 0; it < cfg_max_iter; it++) begin
         for (int i = 0; i < n; i++) begin
            s = 0;
            for (int j = 0; j < n; j++)
               s = s + 66'(matrix_copy[i*STORE_N+j]) * vec[j];
            jv[i] = clamp_bits(s >>> 22, 40);
         end
         acc = 0;
         for (int i = 0; i < n; i++) begin
            acc = acc + vec[i] * jv[i];
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
         end
         lam = clamp_bits(acc >>> 22, 40);
         if (magnitude(lam - prev) < 64'(cfg_tolerance)) return sat32(magnitude(lam));
         prev = lam;
         sq = 0;
         for (int i = 0; i < n; i++) begin
            a = magnitude(jv[i]);
            t = (a >= 64'h1_0000_0000) ? '1 : a * a;
            sq = (sq > ~64'd0 - t) ? '1 : sq + t;
         end
         nrm = int_sqrt(sq);
         if (nrm == 0) break;
         for (int i = 0; i < n; i++) begin
            q = (magnitude(jv[i]) << 22) / nrm;
            if (q > (64'd1 << 24)) q = 64'd1 << 24;
            vec[i] = clamp_bits(jv[i] < 0 ? -66'(q) : 66'(q), 24);
         end
      end
      return sat32(magnitude(prev));
   endfunction

   function automatic radius_result_type predict_radius();
      radius_result_type res;
      int n;
      logic [63:0] g;
      logic [63:0] thr;
      logic [63:0] est;
      bit use_power;
      n = cfg_size > STORE_N ? STORE_N : cfg_size;
      g = row_sum_bound(n);
      thr = 64'd65536 - 64'(cfg_epsilon);
      if (cfg_mode == sre_pkg::MODE_GERSH) use_power = 0;
      else if (cfg_mode == sre_pkg::MODE_POWER) use_power = 1;
      else use_power = (g < thr) && (g * 20 > thr * 19);
      est = use_power ? power_estimate(n) : g;
      res.bound = est[31:0];
      res.contractive = est < thr;
      res.gersh = g[31:0];
      res.used_power = use_power;
      return res;
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 18);
   endfunction

   task automatic send_element(input logic [3:0] r, input logic [3:0] c,
                               input logic signed [23:0] e, input logic last);
      int gap;
      gap = draw_gap();
      repeat (gap) begin
         @(negedge clock);
         req.valid = 1'b0;
      end
      @(negedge clock);
      req.valid = 1'b1;
      req.row_index = r;
      req.col_index = c;
      req.element = e;
      req.last_element = last;
      forever begin
         @(posedge clock);
         if (req.ready) break;
      end
      matrix_copy[r*STORE_N+c] = e;
      written[r*STORE_N+c] = 1;
      sent_count++;
      if (last) pending_radii.push_back(predict_radius());
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending_radii.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_register(input logic [sre_pkg::CSR_IDX_W-1:0] idx,
                               input logic [15:0] value);
      wait_idle();
      @(negedge clock);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.wdata = value;
      forever begin
         @(posedge clock);
         if (csr.ready) break;
      end
      @(negedge clock);
      csr.valid = 1'b0;
      case (idx)
         sre_pkg::CSR_MATRIX_SIZE:    cfg_size = value[4:0];
         sre_pkg::CSR_EPSILON:        cfg_epsilon = value;
         sre_pkg::CSR_MAX_ITERATIONS: cfg_max_iter = value[9:0];
         sre_pkg::CSR_TOLERANCE:      cfg_tolerance = value;
         sre_pkg::CSR_MODE:           cfg_mode = value[1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [4:0] size, input logic [15:0] eps,
                            input logic [9:0] iters, input logic [15:0] tol,
                            input logic [1:0] mode);
      set_register(sre_pkg::CSR_MATRIX_SIZE, 16'(size));
      set_register(sre_pkg::CSR_EPSILON, eps);
      set_register(sre_pkg::CSR_MAX_ITERATIONS, 16'(iters));
      set_register(sre_pkg::CSR_TOLERANCE, tol);
      set_register(sre_pkg::CSR_MODE, 16'(mode));
   endtask

   function automatic logic signed [23:0] draw_element(input fill_kind_type kind, input int r,
                                                       input int c, input int n);
      int lim;
      int v;
      case (kind)
         FILL_SMALL: begin
            lim = 131072 / (n == 0 ? 1 : n);
            v = int'($urandom_range(0, 2 * lim)) - lim;
            return 24'(v);
         end
         FILL_BORDER: begin
            if (r == c) v = int'($urandom_range(60500, 65000));
            else v = int'($urandom_range(0, 40)) - 20;
            if (r == c && $urandom_range(0, 1)) v = -v;
            return 24'(v);
         end
         FILL_EXTREME: begin
            case ($urandom_range(0, 4))
               0: return 24'sh800000;
               1: return 24'sh7FFFFF;
               2: return 24'sd0;
               3: return -24'sd1;
               default: return 24'sd1;
            endcase
         end
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic int active_n();
      return cfg_size > STORE_N ? STORE_N : cfg_size;
   endfunction

   // writes each active entry from a random start, the last one marked; one random entry if none is active
   task automatic load_matrix(input fill_kind_type kind);
      int n;
      int nn;
      int rot;
      int pos;
      n = active_n();
      nn = n * n;
      if (nn == 0) begin
         send_element(4'($urandom), 4'($urandom), draw_element(kind, 0, 1, 1), 1'b1);
         return;
      end
      rot = $urandom_range(0, nn - 1);
      for (int i = 0; i < nn; i++) begin
         pos = (i + rot) % nn;
         send_element(4'(pos / n), 4'(pos % n), draw_element(kind, pos / n, pos % n, n),
                      i == nn - 1);
      end
   endtask

   function automatic bit active_written();
      int n;
      n = active_n();
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (!written[i*STORE_N+j]) return 0;
      return 1;
   endfunction

   // one to four entries inside the active square (anywhere when it is empty) change, the last of them marked
   task automatic update_matrix(input fill_kind_type kind);
      int n;
      int k;
      int r;
      int c;
      n = active_n();
      k = $urandom_range(1, 4);
      for (int i = 0; i < k; i++) begin
         r = n == 0 ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
         c = n == 0 ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
         send_element(4'(r), 4'(c), draw_element(kind, r, c, n), i == k - 1);
      end
   endtask

   task automatic test_reset_defaults();
      load_matrix(FILL_SMALL);
      load_matrix(FILL_EXTREME);
      send_element(4'hF, 4'hF, 24'sh7FFFFF, 1'b1);
      send_element(4'h0, 4'h0, 24'sh800000, 1'b1);
   endtask

   task automatic test_register_extremes();
      configure(5'd31, 16'd0, 10'd3, 16'hFFFF, sre_pkg::MODE_GERSH);
      send_element(4'h3, 4'hC, 24'sh800000, 1'b1);
      configure(5'd0, 16'hFFFF, 10'd1023, 16'd1, sre_pkg::MODE_POWER);
      send_element(4'h5, 4'hA, 24'sh123456, 1'b1);
      configure(5'd16, 16'd655, 10'd3, 16'd0, sre_pkg::MODE_POWER);
      update_matrix(FILL_SMALL);
      configure(5'd2, 16'd3000, 10'd0, 16'd1, sre_pkg::MODE_POWER);
      load_matrix(FILL_BORDER);
      set_register(sre_pkg::CSR_MODE, 16'd3);
      set_register(sre_pkg::CSR_MAX_ITERATIONS, 16'd50);
      load_matrix(FILL_BORDER);
   endtask

   task automatic test_single_element_power();
      configure(5'd1, 16'd655, 10'd1023, 16'd0, sre_pkg::MODE_POWER);
      send_element(4'd0, 4'd0, 24'sd0, 1'b1);
      send_element(4'd0, 4'd0, -24'sd196608, 1'b1);
      set_register(sre_pkg::CSR_TOLERANCE, 16'd1);
      send_element(4'd0, 4'd0, 24'sh7FFFFF, 1'b1);
      send_element(4'd0, 4'd0, 24'sd62000, 1'b1);
      configure(5'd3, 16'd655, 10'd40, 16'd1, sre_pkg::MODE_ANALYZE);
      load_matrix(FILL_BORDER);
   endtask

   task automatic test_random_matrices();
      int n;
      int pick;
      fill_kind_type kind;
      logic [4:0] size;
      logic [9:0] iters;
      while (sent_count < TARGET_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) size = 5'($urandom_range(1, 4));
         else if (pick < 9) size = 5'($urandom_range(5, 8));
         else size = 5'($urandom_range(0, 31));
         iters = $urandom_range(0, 9) == 0 ? 10'd0 : 10'($urandom_range(1, 12));
         if (size > 8) iters = 10'($urandom_range(0, 3));
         configure(size, $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 5000)),
                   iters,
                   $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200)),
                   2'($urandom_range(0, 3)));
         no_gaps = $urandom_range(0, 3) == 0;
         n = active_n();
         repeat ($urandom_range(2, 6)) begin
            kind = fill_kind_type'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 6))
                  send_element(4'($urandom), 4'($urandom), 24'($urandom), 1'b0);
            if (active_written() && $urandom_range(0, 1)) update_matrix(kind);
            else load_matrix(kind);
         end
         no_gaps = 0;
      end
   endtask

   initial begin
      forever begin
         repeat (no_gaps ? 0 : $urandom_range(0, 18)) begin
            @(negedge clock);
            rsp.ready = 1'b0;
         end
         @(negedge clock);
         rsp.ready = 1'b1;
         forever begin
            @(posedge clock);
            if (rsp.valid) break;
         end
      end
   end

   always @(posedge clock) begin
      radius_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_radii.size() == 0) begin
            $error("result transaction with no expected result");
            fail_count++;
         end else begin
            want = pending_radii.pop_front();
            if (rsp.spectral_bound !== want.bound) begin
               $error("spectral_bound expected %0h actual %0h", want.bound, rsp.spectral_bound);
               fail_count++;
            end
            if (rsp.contractive !== want.contractive) begin
               $error("contractive expected %0b actual %0b", want.contractive, rsp.contractive);
               fail_count++;
            end
            if (rsp.gershgorin_value !== want.gersh) begin
               $error("gershgorin_value expected %0h actual %0h", want.gersh,
                      rsp.gershgorin_value);
               fail_count++;
            end
            if (rsp.used_power_iteration !== want.used_power) begin
               $error("used_power_iteration expected %0b actual %0b", want.used_power,
                      rsp.used_power_iteration);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.row_index = '0;
      req.col_index = '0;
      req.element = '0;
      req.last_element = 1'b0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.wdata = '0;
      fail_count = 0;
      sent_count = 0;
      no_gaps = 0;
      cycle_count = 0;
      cfg_size = 5'd16;
      cfg_epsilon = 16'd655;
      cfg_max_iter = 10'd100;
      cfg_tolerance = 16'd1;
      cfg_mode = sre_pkg::MODE_ANALYZE;
      for (int i = 0; i < STORE_N*STORE_N; i++) begin
         matrix_copy[i] = '0;
         written[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_single_element_power();
      test_random_matrices();
      wait_idle();
      if (fail_count == 0 && pending_radii.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
